FILE: rtl/core/djmcs_pkg.sv
// ----------------------------------------------------------------------------
// djmcs_pkg
// shared constants and types for the deadline job scheduler
// ----------------------------------------------------------------------------
package djmcs_pkg;

    localparam int unsigned DEF_MAX_JOBS  = 1024;
    localparam int unsigned DEF_TIME_BITS = 32;
    localparam int unsigned FIELD_BITS    = 32;
    localparam int unsigned COUNT_BITS    = 11;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_SORT_NEXT,   // advance to next run pair or pass
        ST_SORT_RDA,    // read head of run a
        ST_SORT_CAPA,   // capture head a, read head of run b
        ST_SORT_CAPB,   // capture head b
        ST_SORT_WR,     // compare and write one merged word
        ST_SORT_CAP,    // capture the new head of the run that advanced
        ST_COPY_RD,
        ST_COPY_WR,
        ST_SCAN_RD,
        ST_SCAN_EVAL,
        ST_PUSH_RD,
        ST_PUSH_CMP,
        ST_DOWN_RD,
        ST_DOWN_RD2,
        ST_DOWN_CMP,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;         // store an incoming job
        logic clr_set;      // clear count/overflow for next set
        logic sort_init;    // start merge sort
        logic pair_init;    // set up bounds of the next run pair
        logic cap_a;
        logic cap_b;
        logic sort_wr;
        logic sort_cap;
        logic sort_next;
        logic copy_init;
        logic copy_wr;
        logic scan_init;
        logic scan_rd;
        logic scan_eval;
        logic push_rd;
        logic push_cmp;
        logic down_rd;
        logic down_rd2;
        logic down_cmp;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic sort_done;        // width reached job count
        logic pass_done;        // all pairs of this width merged
        logic merge_done;       // current pair finished
        logic copy_done;
        logic scan_done;
        logic eval_push;        // job fits
        logic eval_repl;        // job replaces the heap top
        logic push_go;          // sift up not at the root yet
        logic push_up;          // parent smaller than the moving value
        logic down_go;          // left child exists
        logic down_up;          // larger child above the moving value
    } t_sts;

endpackage

FILE: rtl/core/djmcs_if.sv
// ----------------------------------------------------------------------------
// djmcs_if
// valid/ready channel carrying one word
// ----------------------------------------------------------------------------
interface djmcs_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] duration;
    logic [31:0] deadline;
    logic        last;
    modport source (output valid, duration, deadline, last, input ready);
    modport sink (input valid, duration, deadline, last, output ready);
endinterface

interface djmcs_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] scheduled_count;
    logic        overflow;
    modport source (output valid, scheduled_count, overflow, input ready);
    modport sink (input valid, scheduled_count, overflow, output ready);
endinterface

FILE: rtl/core/djmcs_ram.sv
// ----------------------------------------------------------------------------
// djmcs_ram
// single write port, single read port RAM with registered read
// ----------------------------------------------------------------------------
module djmcs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/djmcs_ctrl.sv
// ----------------------------------------------------------------------------
// djmcs_ctrl
// sequencer for load, merge sort, greedy scan and heap updates
// ----------------------------------------------------------------------------
module djmcs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  djmcs_pkg::t_sts   i_sts,
    output djmcs_pkg::t_cmd   o_cmd
);
    import djmcs_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        o_cmd.sort_init = 1'b1;
                        n_state = ST_SORT_NEXT;
                    end
                end
            end
            ST_SORT_NEXT: begin
                if (i_sts.sort_done) begin
                    o_cmd.scan_init = 1'b1;
                    n_state = ST_SCAN_RD;
                end else if (i_sts.pass_done) begin
                    o_cmd.copy_init = 1'b1;
                    n_state = ST_COPY_RD;
                end else begin
                    o_cmd.pair_init = 1'b1;
                    n_state = ST_SORT_RDA;
                end
            end
            ST_SORT_RDA: n_state = ST_SORT_CAPA;
            ST_SORT_CAPA: begin
                o_cmd.cap_a = 1'b1;
                n_state = ST_SORT_CAPB;
            end
            ST_SORT_CAPB: begin
                o_cmd.cap_b = 1'b1;
                n_state = ST_SORT_WR;
            end
            ST_SORT_WR: begin
                o_cmd.sort_wr = 1'b1;
                if (i_sts.merge_done) begin
                    o_cmd.sort_next = 1'b1;
                    n_state = ST_SORT_NEXT;
                end else begin
                    n_state = ST_SORT_CAP;
                end
            end
            ST_SORT_CAP: begin
                o_cmd.sort_cap = 1'b1;
                n_state = ST_SORT_WR;
            end
            ST_COPY_RD: n_state = ST_COPY_WR;
            ST_COPY_WR: begin
                o_cmd.copy_wr = 1'b1;
                n_state = i_sts.copy_done ? ST_SORT_NEXT : ST_COPY_RD;
            end
            ST_SCAN_RD: begin
                if (i_sts.scan_done) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state = ST_SCAN_EVAL;
                end
            end
            ST_SCAN_EVAL: begin
                o_cmd.scan_eval = 1'b1;
                if (i_sts.eval_push) n_state = ST_PUSH_RD;
                else if (i_sts.eval_repl) n_state = ST_DOWN_RD;
                else n_state = ST_SCAN_RD;
            end
            ST_PUSH_RD: begin
                o_cmd.push_rd = 1'b1;
                n_state = i_sts.push_go ? ST_PUSH_CMP : ST_SCAN_RD;
            end
            ST_PUSH_CMP: begin
                o_cmd.push_cmp = 1'b1;
                n_state = i_sts.push_up ? ST_PUSH_RD : ST_SCAN_RD;
            end
            ST_DOWN_RD: begin
                o_cmd.down_rd = 1'b1;
                n_state = i_sts.down_go ? ST_DOWN_RD2 : ST_SCAN_RD;
            end
            ST_DOWN_RD2: begin
                o_cmd.down_rd2 = 1'b1;
                n_state = ST_DOWN_CMP;
            end
            ST_DOWN_CMP: begin
                o_cmd.down_cmp = 1'b1;
                n_state = i_sts.down_up ? ST_DOWN_RD : ST_SCAN_RD;
            end
            ST_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.clr_set = 1'b1;
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end
endmodule

FILE: rtl/core/djmcs_dp.sv
// ----------------------------------------------------------------------------
// djmcs_dp
// job store, sort buffer, heap memory and arithmetic for the greedy pass
// ----------------------------------------------------------------------------
module djmcs_dp #(
    parameter int unsigned MAX_JOBS  = djmcs_pkg::DEF_MAX_JOBS,
    parameter int unsigned TIME_BITS = djmcs_pkg::DEF_TIME_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  djmcs_pkg::t_cmd                     i_cmd,
    output djmcs_pkg::t_sts                     o_sts,
    input  logic [djmcs_pkg::FIELD_BITS-1:0]    i_duration,
    input  logic [djmcs_pkg::FIELD_BITS-1:0]    i_deadline,
    output logic [djmcs_pkg::COUNT_BITS-1:0]    o_scheduled_count,
    output logic                                o_overflow
);
    import djmcs_pkg::*;

    localparam int unsigned AW  = $clog2(MAX_JOBS);
    localparam int unsigned CW  = AW + 1;
    localparam int unsigned XW  = CW + 1;
    localparam int unsigned EW  = TIME_BITS + AW + 1;
    localparam int unsigned JW  = 2 * TIME_BITS;
    localparam int unsigned TFB = (TIME_BITS < FIELD_BITS) ? TIME_BITS : FIELD_BITS;

    // ------------------------------------------------------------------ memories
    logic          st_we, tb_we, hp_we;
    logic [AW-1:0] st_wa, st_ra, tb_wa, tb_ra, hp_wa, hp_ra;
    logic [JW-1:0] st_wd, st_rd, tb_wd, tb_rd;
    logic [TIME_BITS-1:0] hp_wd, hp_rd;

    djmcs_ram #(.WIDTH(JW), .DEPTH(MAX_JOBS)) u_store (
        .i_clk, .i_we(st_we), .i_waddr(st_wa), .i_wdata(st_wd),
        .i_raddr(st_ra), .o_rdata(st_rd));
    djmcs_ram #(.WIDTH(JW), .DEPTH(MAX_JOBS)) u_tmp (
        .i_clk, .i_we(tb_we), .i_waddr(tb_wa), .i_wdata(tb_wd),
        .i_raddr(tb_ra), .o_rdata(tb_rd));
    djmcs_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_JOBS)) u_heap (
        .i_clk, .i_we(hp_we), .i_waddr(hp_wa), .i_wdata(hp_wd),
        .i_raddr(hp_ra), .o_rdata(hp_rd));

    // ------------------------------------------------------------------ registers
    logic [CW-1:0] r_cnt;               // jobs stored
    logic          r_ovf;
    logic [CW-1:0] r_width, r_lo, r_a, r_b, r_k, r_mid, r_hi;
    logic          r_took_a;            // run a advanced on the last merge write
    logic [JW-1:0] r_ja, r_jb;          // heads of runs a and b
    logic [CW-1:0] r_i;                 // scan index / copy index
    logic [CW-1:0] r_hsize;
    logic [EW-1:0] r_elapsed;
    logic [TIME_BITS-1:0] r_top, r_val; // heap root and moving value
    logic [CW-1:0] r_pos;               // hole position of the sift
    logic [TIME_BITS-1:0] r_lv;         // left child value

    // merge helpers
    logic [XW-1:0] mid_s, hi_s;
    logic [CW-1:0] mid_c, hi_c, a_nx, b_nx;
    logic          a_ok, b_ok, take_a;

    assign mid_s  = {1'b0, r_lo} + {1'b0, r_width};
    assign hi_s   = {1'b0, r_lo} + {r_width, 1'b0};
    assign mid_c  = (mid_s < {1'b0, r_cnt}) ? mid_s[CW-1:0] : r_cnt;
    assign hi_c   = (hi_s < {1'b0, r_cnt}) ? hi_s[CW-1:0] : r_cnt;
    assign a_nx   = r_a + CW'(1);
    assign b_nx   = r_b + CW'(1);
    assign a_ok   = (r_a < r_mid);
    assign b_ok   = (r_b < r_hi);
    assign take_a = a_ok && (!b_ok || (r_ja[TIME_BITS-1:0] <= r_jb[TIME_BITS-1:0]));

    // scan helpers
    logic [TIME_BITS-1:0] sc_d, sc_dl;
    logic [EW-1:0] sum_fit;
    logic          fit, repl;
    assign sc_d    = st_rd[JW-1:TIME_BITS];
    assign sc_dl   = st_rd[TIME_BITS-1:0];
    assign sum_fit = r_elapsed + EW'(sc_d);
    assign fit     = (sum_fit <= EW'(sc_dl));
    assign repl    = (r_hsize != '0) && (sc_d < r_top);

    // sift helpers
    logic [CW-1:0] par, c_sel;
    logic [XW-1:0] lch_w, rch_w;
    logic          take_r;
    logic [TIME_BITS-1:0] cv_sel;
    assign par    = (r_pos - CW'(1)) >> 1;
    assign lch_w  = {r_pos, 1'b1};
    assign rch_w  = lch_w + XW'(1);
    assign take_r = (rch_w < {1'b0, r_hsize}) && (hp_rd > r_lv);
    assign cv_sel = take_r ? hp_rd : r_lv;
    assign c_sel  = take_r ? rch_w[CW-1:0] : lch_w[CW-1:0];

    always_comb begin
        o_sts = '0;
        o_sts.sort_done  = (r_width >= r_cnt);
        o_sts.pass_done  = (r_lo >= r_cnt);
        o_sts.merge_done = ({1'b0, r_k} + XW'(1) >= {1'b0, r_hi});
        o_sts.copy_done  = ({1'b0, r_i} + XW'(1) >= {1'b0, r_cnt});
        o_sts.scan_done  = (r_i >= r_cnt);
        o_sts.eval_push  = fit;
        o_sts.eval_repl  = !fit && repl;
        o_sts.push_go    = (r_pos != '0);
        o_sts.push_up    = (hp_rd < r_val);
        o_sts.down_go    = (lch_w < {1'b0, r_hsize});
        o_sts.down_up    = (cv_sel > r_val);
    end

    // memory port control
    always_comb begin
        st_we = 1'b0; st_wa = r_cnt[AW-1:0];
        st_wd = {TIME_BITS'(i_duration[TFB-1:0]), TIME_BITS'(i_deadline[TFB-1:0])};
        st_ra = r_a[AW-1:0];
        tb_we = 1'b0; tb_wa = r_k[AW-1:0]; tb_wd = take_a ? r_ja : r_jb;
        tb_ra = r_i[AW-1:0];
        hp_we = 1'b0; hp_wa = r_pos[AW-1:0]; hp_wd = r_val;
        hp_ra = par[AW-1:0];
        if (i_cmd.load) st_we = (r_cnt < CW'(MAX_JOBS));
        if (i_cmd.cap_a) st_ra = r_b[AW-1:0];
        if (i_cmd.sort_wr) begin
            tb_we = 1'b1;
            st_ra = take_a ? a_nx[AW-1:0] : b_nx[AW-1:0];
        end
        if (i_cmd.copy_wr) begin
            st_we = 1'b1; st_wa = r_i[AW-1:0]; st_wd = tb_rd;
        end
        if (i_cmd.scan_rd) st_ra = r_i[AW-1:0];
        // the moving value lands in the hole where the sift stops
        if (i_cmd.push_rd) hp_we = (r_pos == '0);
        if (i_cmd.push_cmp) begin
            hp_we = 1'b1;
            if (hp_rd < r_val) hp_wd = hp_rd;
        end
        if (i_cmd.down_rd) begin
            hp_we = !o_sts.down_go;
            hp_ra = lch_w[AW-1:0];
        end
        if (i_cmd.down_rd2) hp_ra = rch_w[AW-1:0];
        if (i_cmd.down_cmp) begin
            hp_we = 1'b1;
            if (cv_sel > r_val) hp_wd = cv_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_ovf <= 1'b0; r_hsize <= '0; r_elapsed <= '0;
        end else if (i_cmd.clr_set) begin
            r_cnt <= '0; r_ovf <= 1'b0; r_hsize <= '0; r_elapsed <= '0;
        end else if (i_cmd.load) begin
            if (r_cnt < CW'(MAX_JOBS)) r_cnt <= r_cnt + CW'(1);
            else r_ovf <= 1'b1;
        end else if (i_cmd.scan_init) begin
            r_hsize <= '0; r_elapsed <= '0;
        end else if (i_cmd.scan_eval) begin
            if (fit) begin
                r_elapsed <= sum_fit;
                r_hsize <= r_hsize + CW'(1);
            end else if (repl) begin
                r_elapsed <= r_elapsed - EW'(r_top) + EW'(sc_d);
            end
        end
    end

    // sort bounds, run heads and sift registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.sort_init) begin
            r_width <= CW'(1); r_lo <= '0;
        end
        if (i_cmd.pair_init) begin
            r_a <= r_lo; r_b <= mid_c; r_mid <= mid_c; r_hi <= hi_c; r_k <= r_lo;
        end
        if (i_cmd.cap_a) r_ja <= st_rd;
        if (i_cmd.cap_b) r_jb <= st_rd;
        if (i_cmd.sort_wr) begin
            r_k <= r_k + CW'(1);
            r_took_a <= take_a;
            if (take_a) r_a <= a_nx;
            else r_b <= b_nx;
        end
        if (i_cmd.sort_cap) begin
            if (r_took_a) r_ja <= st_rd;
            else r_jb <= st_rd;
        end
        if (i_cmd.sort_next) r_lo <= r_hi;
        if (i_cmd.copy_init || i_cmd.scan_init) r_i <= '0;
        if (i_cmd.copy_wr) begin
            r_i <= r_i + CW'(1);
            if (o_sts.copy_done) begin
                r_width <= {r_width[CW-2:0], 1'b0}; r_lo <= '0;
            end
        end
        if (i_cmd.scan_rd) r_i <= r_i + CW'(1);
        if (i_cmd.scan_eval) begin
            if (fit) begin
                r_pos <= r_hsize; r_val <= sc_d;
                if (r_hsize == '0 || sc_d > r_top) r_top <= sc_d;
            end else if (repl) begin
                r_pos <= '0; r_val <= sc_d; r_top <= sc_d;
            end
        end
        if (i_cmd.push_cmp && (hp_rd < r_val)) r_pos <= par;
        if (i_cmd.down_rd2) r_lv <= hp_rd;
        if (i_cmd.down_cmp && (cv_sel > r_val)) begin
            r_pos <= c_sel;
            // a child moving into the root becomes the new top
            if (r_pos == '0) r_top <= cv_sel;
        end
    end

    assign o_scheduled_count = COUNT_BITS'(r_hsize);
    assign o_overflow        = r_ovf;
endmodule

FILE: rtl/core/deadline_job_max_count_scheduler_top.sv
// ----------------------------------------------------------------------------
// deadline_job_max_count_scheduler_top
// counts the most jobs of a set that can all meet their deadlines
// ----------------------------------------------------------------------------
// Jobs are taken one word per cycle while loading. The word with last set
// closes the set; the block then merge sorts the n stored jobs by deadline
// (ceil(log2 n) passes, each a merge and a copy back) and runs the greedy
// pass with a max-heap in a third RAM, climbing heap levels on an insert and
// descending them on a replacement. One result word follows; no job is taken
// after the last word of a set until that result is delivered.
module deadline_job_max_count_scheduler_top #(
    parameter int unsigned MAX_JOBS  = djmcs_pkg::DEF_MAX_JOBS,
    parameter int unsigned TIME_BITS = djmcs_pkg::DEF_TIME_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    djmcs_in_if.sink    in_ch,
    djmcs_out_if.source out_ch
);
    import djmcs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    djmcs_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(in_ch.valid), .i_in_last(in_ch.last), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_sts(sts), .o_cmd(cmd));

    djmcs_dp #(.MAX_JOBS(MAX_JOBS), .TIME_BITS(TIME_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_duration(in_ch.duration), .i_deadline(in_ch.deadline),
        .o_scheduled_count(out_ch.scheduled_count), .o_overflow(out_ch.overflow));
endmodule
